// ----- rtl/ctwb_pkg.sv -----
// ctwb_pkg: types and constants for the cluster time-window boundary core.
// No dependencies.
`default_nettype none
package ctwb_pkg;
  localparam int TICK_W = 14;
  localparam int WIRE_W = 12;
  localparam int MEAN_W = 18;
  localparam int MINW_W = 13;
  localparam logic [8:0] WIRES_UV = 9'd400;
  localparam logic [8:0] WIRES_Z  = 9'd480;
  localparam logic [4:0] TPC_LAST_WS = 5'd23;
  localparam logic [4:0] TPC_LAST_SD = 5'd12;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_LAYOUT    = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD, ST_DIV, ST_SCAN, ST_DRAIN, ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/cluster_time_window_boundary_core.sv -----
// cluster_time_window_boundary_core: collects detector hits into a hit memory,
// then on the last hit runs the per-view mean and window pass. Uses ctwb_pkg.
//
// Hits are taken one per cycle while loading. On a word with last_hit set the
// core stops accepting, divides the three tick sums by their counts with a
// shared restoring divider (a load step and SUM_W+4 quotient bits per view),
// then scans the stored hits out of the hit memory one per cycle, drains the
// read pipeline, and presents a single result word driven from the result registers.
// Input is accepted again once the result word has been taken. Sum and count
// widths follow MAX_HITS.
`default_nettype none
module cluster_time_window_boundary_core import ctwb_pkg::*; #(
  parameter int MAX_HITS = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [23:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [8:0]          local_wire,
  input  wire logic [1:0]          plane,
  input  wire logic [4:0]          tpc,
  input  wire logic [13:0]         tick,
  input  wire logic [23:0]         charge,
  input  wire logic                last_hit,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [12:0]       min_wire_u,
  output logic signed [12:0]       min_wire_v,
  output logic signed [12:0]       min_wire_z,
  output logic [17:0]              mean_time_u,
  output logic [17:0]              mean_time_v,
  output logic [17:0]              mean_time_z,
  output logic [2:0]               empty_views,
  output logic [12:0]              kept_total,
  output logic                     store_overflow
);
  localparam int AW    = $clog2(MAX_HITS);
  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam int SUM_W = CNT_W + TICK_W;
  localparam int NUM_W = SUM_W + 4;
  localparam int PROD_W = SUM_W + 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_HITS);

  // config registers
  logic [23:0] charge_threshold;
  logic [13:0] time_window;
  logic        small_detector_layout;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_threshold      <= '0;
      time_window           <= 14'd1000;
      small_detector_layout <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: charge_threshold <= cfg_data;
        REG_WINDOW:    time_window      <= cfg_data[13:0];
        REG_LAYOUT:    small_detector_layout <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hit mapping
  logic [1:0]  map_view;
  logic [11:0] map_wire;
  logic        map_ok;
  always_comb begin
    logic [8:0] nw;
    logic [1:0] m4;
    logic       keep;
    logic [4:0] blocks;
    nw = (plane == 2'd2) ? WIRES_Z : WIRES_UV;
    m4 = tpc[1:0];
    keep = 1'b0;
    map_view = (plane == 2'd2) ? 2'd2 : 2'd0;
    map_ok = !(small_detector_layout && tpc > 5'd11);
    if (plane < 2'd2) begin
      keep = small_detector_layout ? (m4 == 2'd1) : (m4 == 2'd0 || m4 == 2'd3);
      map_view = keep ? plane : {1'b0, ~plane[0]};
    end
    if (map_view != 2'd1) blocks = {2'b0, tpc[4:2]};
    else if (small_detector_layout) blocks = {2'b0, 3'((TPC_LAST_SD - tpc) >> 2)};
    else blocks = (tpc <= TPC_LAST_WS) ? {2'b0, 3'((TPC_LAST_WS - tpc) >> 2)} : 5'd0;
    map_wire = 12'({3'b0, local_wire} + 21'(blocks) * 21'(nw));
  end

  // hit memory: {view, wire, tick}
  localparam int MEM_W = 2 + WIRE_W + TICK_W;
  logic [MEM_W-1:0] hit_mem [MAX_HITS];
  logic [MEM_W-1:0] rd_data;
  logic             mem_we;
  logic [AW-1:0]    mem_wa, mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) hit_mem[mem_wa] <= {map_view, map_wire, tick};
    rd_data <= hit_mem[mem_ra];
  end

  state_t state, state_next;
  logic [SUM_W-1:0] tick_sum [3];
  logic [CNT_W-1:0] view_count [3];
  logic [CNT_W-1:0] stored_count;
  logic             overflow_flag;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld, rd_vld2;
  logic [MEM_W-1:0] hit_q;
  logic [1:0]       div_view;
  logic [$clog2(NUM_W+1)-1:0] div_step;
  logic [NUM_W-1:0] div_num;
  logic [CNT_W:0]   div_rem;
  logic [MEAN_W-1:0] mean_q [3];
  logic [WIRE_W-1:0] min_w [3];
  logic [2:0]       have_min;
  logic [12:0]      kept;

  wire take = in_valid && in_ready;
  wire hit_used = charge > charge_threshold && map_ok;
  assign mem_we = take && hit_used && stored_count < CAP;
  assign mem_wa = stored_count[AW-1:0];
  assign mem_ra = scan_idx[AW-1:0];
  assign in_ready = (state == ST_LOAD);

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (take && last_hit) state_next = ST_DIV;
      ST_DIV:   if (div_view == 2'd2 && div_step == 0) state_next = ST_SCAN;
      ST_SCAN:  if (scan_idx >= stored_count) state_next = ST_DRAIN;
      ST_DRAIN: if (!rd_vld && !rd_vld2) state_next = ST_DONE;
      ST_DONE:  if (out_ready) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end
  assign out_valid = (state == ST_DONE);

  // window test on registered hit word
  logic [1:0]        hv;
  logic [WIRE_W-1:0] hw;
  logic [TICK_W-1:0] ht;
  logic [PROD_W+1:0] prod_t, lim, diff;
  logic              in_win;
  assign {hv, hw, ht} = hit_q;
  always_comb begin
    logic [1:0] vi;
    vi = (hv > 2'd2) ? 2'd0 : hv;
    prod_t = (PROD_W+2)'(ht) * (PROD_W+2)'(view_count[vi]);
    lim    = (PROD_W+2)'(time_window) * (PROD_W+2)'(view_count[vi]);
    diff   = (prod_t >= (PROD_W+2)'(tick_sum[vi])) ? prod_t - (PROD_W+2)'(tick_sum[vi])
                                                   : (PROD_W+2)'(tick_sum[vi]) - prod_t;
    in_win = hv <= 2'd2 && view_count[vi] != 0 && diff < lim;
  end

  // divider: one quotient bit per cycle
  wire [CNT_W:0] rem_sh = {div_rem[CNT_W-1:0], div_num[NUM_W-1]};
  wire           ge     = rem_sh >= {1'b0, view_count[div_view]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < 3; v++) begin
        tick_sum[v] <= '0;
        view_count[v] <= '0;
      end
      stored_count <= '0;
      overflow_flag <= 1'b0;
      rd_vld <= 1'b0;
      rd_vld2 <= 1'b0;
    end else begin
      rd_vld2 <= rd_vld;
      rd_vld <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (take && hit_used) begin
            if (stored_count < CAP) begin
              stored_count <= stored_count + 1'b1;
              tick_sum[map_view] <= tick_sum[map_view] + SUM_W'(tick);
              view_count[map_view] <= view_count[map_view] + 1'b1;
            end else overflow_flag <= 1'b1;
          end
        end
        ST_SCAN: rd_vld <= scan_idx < stored_count;
        ST_DONE: if (out_ready) begin
          for (int v = 0; v < 3; v++) begin
            tick_sum[v] <= '0;
            view_count[v] <= '0;
          end
          stored_count <= '0;
          overflow_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath regs, no reset needed (reloaded per cluster)
  always_ff @(posedge clk) begin
    hit_q <= rd_data;
    case (state)
      ST_LOAD: begin
        div_view <= 2'd0;
        div_step <= ($clog2(NUM_W+1))'(NUM_W);
        div_num <= '0;
        div_rem <= '0;
        scan_idx <= '0;
        have_min <= '0;
        kept <= '0;
      end
      ST_DIV: begin
        if (div_step == ($clog2(NUM_W+1))'(NUM_W)) begin
          div_num <= {tick_sum[div_view], 4'b0};
          div_rem <= '0;
          div_step <= div_step - 1'b1;
        end else begin
          div_rem <= ge ? rem_sh - {1'b0, view_count[div_view]} : rem_sh;
          div_num <= {div_num[NUM_W-2:0], ge};
          if (div_step == 0) begin
            mean_q[div_view] <= (view_count[div_view] == 0) ? '0
                              : MEAN_W'({div_num[NUM_W-2:0], ge});
            div_view <= div_view + 1'b1;
            div_step <= ($clog2(NUM_W+1))'(NUM_W);
          end else div_step <= div_step - 1'b1;
        end
      end
      ST_SCAN: if (scan_idx < stored_count) scan_idx <= scan_idx + 1'b1;
      default: ;
    endcase
    if (rd_vld2 && in_win) begin
      kept <= kept + 1'b1;
      if (!have_min[hv] || hw < min_w[hv]) begin
        min_w[hv] <= hw;
        have_min[hv] <= 1'b1;
      end
    end
  end

  // divider entry cycle holds div_step at NUM_W then counts NUM_W-1..0 bits
  assign min_wire_u = have_min[0] ? 13'({1'b0, min_w[0]} - 13'd1) : '0;
  assign min_wire_v = have_min[1] ? 13'({1'b0, min_w[1]} - 13'd1) : '0;
  assign min_wire_z = have_min[2] ? 13'({1'b0, min_w[2]} - 13'd1) : '0;
  assign mean_time_u = mean_q[0];
  assign mean_time_v = mean_q[1];
  assign mean_time_z = mean_q[2];
  assign empty_views = {view_count[2] == 0, view_count[1] == 0, view_count[0] == 0};
  assign kept_total = kept;
  assign store_overflow = overflow_flag;

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> !in_ready) else $error("input taken while busy");
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CAP) else $error("stored count past capacity");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kept_total))
    else $error("result word changed while stalled");
endmodule
`default_nettype wire
